>>> sv/bop_pkg.sv
`default_nettype none

package bop_pkg;

    localparam int COORD_BITS = 12;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int PCT_BITS   = 7;
    localparam int NUM_BITS   = AREA_BITS + PCT_BITS;
    localparam int QUOT_STEPS = PCT_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [EDGE_BITS-1:0]  edge_t;
    typedef logic [AREA_BITS-1:0]  area_t;
    typedef logic [NUM_BITS-1:0]   num_t;
    typedef logic [PCT_BITS-1:0]   pct_t;

    localparam pct_t FULL_SCORE = PCT_BITS'(100);
    localparam pct_t ZERO_SCORE = '0;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t aw;
        coord_t ah;
        coord_t bx;
        coord_t by;
        coord_t bw;
        coord_t bh;
    } box_pair_t;

    typedef struct packed {
        logic disjoint;
        logic nested;
    } geo_flags_t;

    typedef struct packed {
        geo_flags_t flags;
        coord_t     aw;
        coord_t     ah;
        coord_t     bw;
        coord_t     bh;
        coord_t     dx;
        coord_t     dy;
    } geo_t;

    typedef struct packed {
        logic  fixed;
        pct_t  fixed_val;
        num_t  rem;
        area_t big;
        pct_t  quo;
    } div_t;

endpackage

`default_nettype wire

>>> sv/box_overlap_percent.sv
`default_nettype none

// Overlap score of two axis-aligned boxes (corner, width, height each) as a whole
// percentage 0..100: 0 for disjoint boxes, 100 when one box holds the other (unless
// ignore_inclusion is set), else 100 * intersection area / larger box area, truncated.
// One word enters per cycle while box_stall is low, and one result word leaves per word
// taken; each word passes twelve register stages: two geometry stages, two area stages,
// seven quotient stages of the pipelined divider (one bit each) and the output register
// that drives result_valid. Stalls propagate back combinationally through the load
// enables of every stage, so bubbles are squeezed out before box_stall rises.
// cfg_ready is always high; write ignore_inclusion only while the pipeline is empty.
module box_overlap_percent (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            ignore_inclusion,
    input  wire logic                            box_valid,
    output logic                                 box_stall,
    input  wire logic [bop_pkg::COORD_BITS-1:0]  box_a_x,
    input  wire logic [bop_pkg::COORD_BITS-1:0]  box_a_y,
    input  wire logic [bop_pkg::COORD_BITS-1:0]  box_a_w,
    input  wire logic [bop_pkg::COORD_BITS-1:0]  box_a_h,
    input  wire logic [bop_pkg::COORD_BITS-1:0]  box_b_x,
    input  wire logic [bop_pkg::COORD_BITS-1:0]  box_b_y,
    input  wire logic [bop_pkg::COORD_BITS-1:0]  box_b_w,
    input  wire logic [bop_pkg::COORD_BITS-1:0]  box_b_h,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [bop_pkg::PCT_BITS-1:0]         overlap_percent
);
    import bop_pkg::*;

    logic      ignore_inclusion_reg;
    box_pair_t box_in;
    logic      geo_load;
    logic      geo_valid;
    geo_t      geo_data;
    logic      area_load;
    logic      area_valid;
    div_t      area_data;
    logic      div_load;
    logic      div_valid;
    pct_t      div_pct;
    logic      out_load;
    logic      result_valid_reg;
    pct_t      overlap_percent_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_inclusion_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ignore_inclusion_reg <= ignore_inclusion;
        end
    end

    assign box_in.ax = box_a_x;
    assign box_in.ay = box_a_y;
    assign box_in.aw = box_a_w;
    assign box_in.ah = box_a_h;
    assign box_in.bx = box_b_x;
    assign box_in.by = box_b_y;
    assign box_in.bw = box_b_w;
    assign box_in.bh = box_b_h;

    bop_geometry u_geometry (
        .clk              (clk),
        .rst_n            (rst_n),
        .ignore_inclusion (ignore_inclusion_reg),
        .up_valid         (box_valid),
        .up_load          (geo_load),
        .up_data          (box_in),
        .dn_valid         (geo_valid),
        .dn_load          (area_load),
        .dn_data          (geo_data)
    );

    bop_area u_area (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (geo_valid),
        .up_load  (area_load),
        .up_data  (geo_data),
        .dn_valid (area_valid),
        .dn_load  (div_load),
        .dn_data  (area_data)
    );

    bop_divide u_divide (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (area_valid),
        .up_load  (div_load),
        .up_data  (area_data),
        .dn_valid (div_valid),
        .dn_load  (out_load),
        .dn_pct   (div_pct)
    );

    assign box_stall = !geo_load;
    assign out_load  = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && div_valid)
        begin
            overlap_percent_reg <= div_pct;
        end
    end

    assign result_valid    = result_valid_reg;
    assign overlap_percent = overlap_percent_reg;

endmodule

`default_nettype wire

>>> sv/bop_geometry.sv
`default_nettype none

module bop_geometry (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ignore_inclusion,
    input  wire logic                up_valid,
    output logic                     up_load,
    input  wire bop_pkg::box_pair_t  up_data,
    output logic                     dn_valid,
    input  wire logic                dn_load,
    output bop_pkg::geo_t            dn_data
);
    import bop_pkg::*;

    typedef struct packed {
        edge_t  lo_x;
        edge_t  lo_y;
        edge_t  hi_x;
        edge_t  hi_y;
        edge_t  ov_x0;
        edge_t  ov_y0;
        edge_t  ov_x1;
        edge_t  ov_y1;
        coord_t aw;
        coord_t ah;
        coord_t bw;
        coord_t bh;
    } span_t;

    logic  s1_valid_reg;
    span_t s1_reg;
    span_t s1_next;
    logic  s1_load;
    logic  s2_valid_reg;
    geo_t  s2_reg;
    geo_t  s2_next;
    logic  s2_load;

    edge_t ax1;
    edge_t ay1;
    edge_t bx1;
    edge_t by1;
    edge_t ext_x;
    edge_t ext_y;
    edge_t span_x;
    edge_t span_y;
    logic  a_cover;
    logic  b_cover;

    assign s2_load = !s2_valid_reg || dn_load;
    assign s1_load = !s1_valid_reg || s2_load;
    assign up_load = s1_load;

    always_comb
    begin
        ax1 = EDGE_BITS'(up_data.ax) + EDGE_BITS'(up_data.aw);
        ay1 = EDGE_BITS'(up_data.ay) + EDGE_BITS'(up_data.ah);
        bx1 = EDGE_BITS'(up_data.bx) + EDGE_BITS'(up_data.bw);
        by1 = EDGE_BITS'(up_data.by) + EDGE_BITS'(up_data.bh);
        if (up_data.ax <= up_data.bx)
        begin
            s1_next.lo_x  = EDGE_BITS'(up_data.ax);
            s1_next.ov_x0 = EDGE_BITS'(up_data.bx);
        end
        else
        begin
            s1_next.lo_x  = EDGE_BITS'(up_data.bx);
            s1_next.ov_x0 = EDGE_BITS'(up_data.ax);
        end
        if (up_data.ay <= up_data.by)
        begin
            s1_next.lo_y  = EDGE_BITS'(up_data.ay);
            s1_next.ov_y0 = EDGE_BITS'(up_data.by);
        end
        else
        begin
            s1_next.lo_y  = EDGE_BITS'(up_data.by);
            s1_next.ov_y0 = EDGE_BITS'(up_data.ay);
        end
        if (ax1 >= bx1)
        begin
            s1_next.hi_x  = ax1;
            s1_next.ov_x1 = bx1;
        end
        else
        begin
            s1_next.hi_x  = bx1;
            s1_next.ov_x1 = ax1;
        end
        if (ay1 >= by1)
        begin
            s1_next.hi_y  = ay1;
            s1_next.ov_y1 = by1;
        end
        else
        begin
            s1_next.hi_y  = by1;
            s1_next.ov_y1 = ay1;
        end
        s1_next.aw = up_data.aw;
        s1_next.ah = up_data.ah;
        s1_next.bw = up_data.bw;
        s1_next.bh = up_data.bh;
    end

    always_comb
    begin
        ext_x   = s1_reg.hi_x - s1_reg.lo_x;
        ext_y   = s1_reg.hi_y - s1_reg.lo_y;
        span_x  = s1_reg.ov_x1 - s1_reg.ov_x0;
        span_y  = s1_reg.ov_y1 - s1_reg.ov_y0;
        a_cover = (ext_x == EDGE_BITS'(s1_reg.aw)) && (ext_y == EDGE_BITS'(s1_reg.ah));
        b_cover = (ext_x == EDGE_BITS'(s1_reg.bw)) && (ext_y == EDGE_BITS'(s1_reg.bh));
        s2_next.flags.disjoint = (s1_reg.ov_x1 < s1_reg.ov_x0)
                              || (s1_reg.ov_y1 < s1_reg.ov_y0);
        s2_next.flags.nested   = !ignore_inclusion && (a_cover || b_cover);
        s2_next.aw = s1_reg.aw;
        s2_next.ah = s1_reg.ah;
        s2_next.bw = s1_reg.bw;
        s2_next.bh = s1_reg.bh;
        s2_next.dx = span_x[COORD_BITS-1:0];
        s2_next.dy = span_y[COORD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && up_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_reg;

endmodule

`default_nettype wire

>>> sv/bop_area.sv
`default_nettype none

module bop_area (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_load,
    input  wire bop_pkg::geo_t  up_data,
    output logic                dn_valid,
    input  wire logic           dn_load,
    output bop_pkg::div_t       dn_data
);
    import bop_pkg::*;

    typedef struct packed {
        geo_flags_t flags;
        area_t      area_a;
        area_t      area_b;
        area_t      inter;
    } prod_t;

    logic  s1_valid_reg;
    prod_t s1_reg;
    prod_t s1_next;
    logic  s1_load;
    logic  s2_valid_reg;
    div_t  s2_reg;
    div_t  s2_next;
    logic  s2_load;
    area_t big;

    assign s2_load = !s2_valid_reg || dn_load;
    assign s1_load = !s1_valid_reg || s2_load;
    assign up_load = s1_load;

    always_comb
    begin
        s1_next.flags  = up_data.flags;
        s1_next.area_a = AREA_BITS'(up_data.aw) * AREA_BITS'(up_data.ah);
        s1_next.area_b = AREA_BITS'(up_data.bw) * AREA_BITS'(up_data.bh);
        s1_next.inter  = AREA_BITS'(up_data.dx) * AREA_BITS'(up_data.dy);
    end

    always_comb
    begin
        big = (s1_reg.area_b > s1_reg.area_a) ? s1_reg.area_b : s1_reg.area_a;
        s2_next.big = big;
        s2_next.rem = NUM_BITS'(s1_reg.inter) * NUM_BITS'(FULL_SCORE);
        s2_next.quo = '0;
        if (s1_reg.flags.disjoint)
        begin
            s2_next.fixed     = 1'b1;
            s2_next.fixed_val = ZERO_SCORE;
        end
        else if (s1_reg.flags.nested)
        begin
            s2_next.fixed     = 1'b1;
            s2_next.fixed_val = FULL_SCORE;
        end
        else if (big == '0)
        begin
            s2_next.fixed     = 1'b1;
            s2_next.fixed_val = ZERO_SCORE;
        end
        else
        begin
            s2_next.fixed     = 1'b0;
            s2_next.fixed_val = ZERO_SCORE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && up_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_reg;

endmodule

`default_nettype wire

>>> sv/bop_divide.sv
`default_nettype none

module bop_divide (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_load,
    input  wire bop_pkg::div_t  up_data,
    output logic                dn_valid,
    input  wire logic           dn_load,
    output bop_pkg::pct_t       dn_pct
);
    import bop_pkg::*;

    logic [QUOT_STEPS-1:0] valid_reg;
    logic [QUOT_STEPS-1:0] load;
    div_t                  stage_reg [QUOT_STEPS];

    genvar i;
    generate
        for (i = 0; i < QUOT_STEPS; i++)
        begin : g_step
            localparam int QBIT = QUOT_STEPS - 1 - i;

            div_t stage_in;
            div_t stage_next;
            logic in_valid;
            num_t trial;

            if (i == 0)
            begin : g_first
                assign stage_in = up_data;
                assign in_valid = up_valid;
            end
            else
            begin : g_rest
                assign stage_in = stage_reg[i-1];
                assign in_valid = valid_reg[i-1];
            end

            if (i == QUOT_STEPS - 1)
            begin : g_last
                assign load[i] = !valid_reg[i] || dn_load;
            end
            else
            begin : g_mid
                assign load[i] = !valid_reg[i] || load[i+1];
            end

            // restore-free step: subtract the shifted divisor when it fits
            always_comb
            begin
                trial      = NUM_BITS'(stage_in.big) << QBIT;
                stage_next = stage_in;
                if (stage_in.rem >= trial)
                begin
                    stage_next.rem       = stage_in.rem - trial;
                    stage_next.quo[QBIT] = 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (load[i])
                begin
                    valid_reg[i] <= in_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (load[i] && in_valid)
                begin
                    stage_reg[i] <= stage_next;
                end
            end
        end
    endgenerate

    assign up_load  = load[0];
    assign dn_valid = valid_reg[QUOT_STEPS-1];
    assign dn_pct   = stage_reg[QUOT_STEPS-1].fixed ? stage_reg[QUOT_STEPS-1].fixed_val
                                                    : stage_reg[QUOT_STEPS-1].quo;

endmodule

`default_nettype wire

>>> tb/sv/box_overlap_checker.sv
`timescale 1ns / 1ps

module box_overlap_checker
    import bop_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic                  ignore_inclusion,
    input  wire logic                  box_valid,
    input  wire logic                  box_stall,
    input  wire logic [COORD_BITS-1:0] box_a_x,
    input  wire logic [COORD_BITS-1:0] box_a_y,
    input  wire logic [COORD_BITS-1:0] box_a_w,
    input  wire logic [COORD_BITS-1:0] box_a_h,
    input  wire logic [COORD_BITS-1:0] box_b_x,
    input  wire logic [COORD_BITS-1:0] box_b_y,
    input  wire logic [COORD_BITS-1:0] box_b_w,
    input  wire logic [COORD_BITS-1:0] box_b_h,
    input  wire logic                  result_valid,
    input  wire logic                  result_stall,
    input  wire logic [PCT_BITS-1:0]   overlap_percent,
    output int                         mismatches,
    output int                         pending
);

    localparam longint PERCENT = 100;

    pct_t      expected_scores[$];
    logic      skip_inclusion;
    box_pair_t pair_in;
    pct_t      want;

    assign pending = expected_scores.size();

    assign pair_in = '{ax: box_a_x, ay: box_a_y, aw: box_a_w, ah: box_a_h,
                       bx: box_b_x, by: box_b_y, bw: box_b_w, bh: box_b_h};

    function automatic pct_t overlap_score(input box_pair_t p, input logic skip_incl);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint ax1, ay1, bx1, by1;
        longint lo_x, lo_y, hi_x, hi_y;
        longint ov_x0, ov_y0, ov_x1, ov_y1;
        longint ext_x, ext_y, area_a, area_b, big, inter;
        ax = p.ax;
        ay = p.ay;
        aw = p.aw;
        ah = p.ah;
        bx = p.bx;
        by = p.by;
        bw = p.bw;
        bh = p.bh;
        ax1 = ax + aw;
        ay1 = ay + ah;
        bx1 = bx + bw;
        by1 = by + bh;
        lo_x = (ax <= bx) ? ax : bx;
        lo_y = (ay <= by) ? ay : by;
        hi_x = (ax1 >= bx1) ? ax1 : bx1;
        hi_y = (ay1 >= by1) ? ay1 : by1;
        ov_x0 = (ax <= bx) ? bx : ax;
        ov_y0 = (ay <= by) ? by : ay;
        ov_x1 = (ax1 >= bx1) ? bx1 : ax1;
        ov_y1 = (ay1 >= by1) ? by1 : ay1;
        if (ov_x1 < ov_x0 || ov_y1 < ov_y0)
            return ZERO_SCORE;
        ext_x = hi_x - lo_x;
        ext_y = hi_y - lo_y;
        if (!skip_incl && ((ext_x == aw && ext_y == ah) || (ext_x == bw && ext_y == bh)))
            return FULL_SCORE;
        area_a = aw * ah;
        area_b = bw * bh;
        big = (area_b > area_a) ? area_b : area_a;
        inter = (ov_x1 - ov_x0) * (ov_y1 - ov_y0);
        if (big == 0)
            return ZERO_SCORE;
        return pct_t'((PERCENT * inter) / big);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_inclusion = 1'b0;
            expected_scores.delete();
            mismatches = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_scores.size() == 0)
                begin
                    $display("%0t: overlap_percent %0d with no word pending",
                             $time, overlap_percent);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (overlap_percent !== want)
                    begin
                        $display("%0t: overlap_percent expected %0d actual %0d",
                                 $time, want, overlap_percent);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (box_valid && !box_stall)
                expected_scores.push_back(overlap_score(pair_in, skip_inclusion));
            if (cfg_valid && cfg_ready)
                skip_inclusion = ignore_inclusion;
        end
    end

endmodule

>>> tb/sv/tb_box_overlap_percent.sv
`timescale 1ns / 1ps

module tb_box_overlap_percent;

    import bop_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_STRETCH = 150;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  ignore_inclusion;
    logic                  box_valid;
    logic                  box_stall;
    logic [COORD_BITS-1:0] box_a_x;
    logic [COORD_BITS-1:0] box_a_y;
    logic [COORD_BITS-1:0] box_a_w;
    logic [COORD_BITS-1:0] box_a_h;
    logic [COORD_BITS-1:0] box_b_x;
    logic [COORD_BITS-1:0] box_b_y;
    logic [COORD_BITS-1:0] box_b_w;
    logic [COORD_BITS-1:0] box_b_h;
    logic                  result_valid;
    logic                  result_stall;
    logic [PCT_BITS-1:0]   overlap_percent;
    int                    mismatches;
    int                    pending;
    bit                    quiet = 1'b0;

    box_overlap_percent uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .ignore_inclusion (ignore_inclusion),
        .box_valid        (box_valid),
        .box_stall        (box_stall),
        .box_a_x          (box_a_x),
        .box_a_y          (box_a_y),
        .box_a_w          (box_a_w),
        .box_a_h          (box_a_h),
        .box_b_x          (box_b_x),
        .box_b_y          (box_b_y),
        .box_b_w          (box_b_w),
        .box_b_h          (box_b_h),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .overlap_percent  (overlap_percent)
    );

    box_overlap_checker score_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .ignore_inclusion (ignore_inclusion),
        .box_valid        (box_valid),
        .box_stall        (box_stall),
        .box_a_x          (box_a_x),
        .box_a_y          (box_a_y),
        .box_a_w          (box_a_w),
        .box_a_h          (box_a_h),
        .box_b_x          (box_b_x),
        .box_b_y          (box_b_y),
        .box_b_w          (box_b_w),
        .box_b_h          (box_b_h),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .overlap_percent  (overlap_percent),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int idle_cycles();
        return quiet ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic box_pair_t make_pair(input int ax, input int ay, input int aw,
                                            input int ah, input int bx, input int by,
                                            input int bw, input int bh);
        box_pair_t p;
        p.ax = coord_t'(ax);
        p.ay = coord_t'(ay);
        p.aw = coord_t'(aw);
        p.ah = coord_t'(ah);
        p.bx = coord_t'(bx);
        p.by = coord_t'(by);
        p.bw = coord_t'(bw);
        p.bh = coord_t'(bh);
        return p;
    endfunction

    function automatic int random_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 70)
            return $urandom_range(1, 64);
        if (r < 90)
            return $urandom_range(1, 512);
        return $urandom_range(1, 4095);
    endfunction

    function automatic box_pair_t random_pair();
        int ax, ay, aw, ah, bx, by, bw, bh;
        int kind;
        ax = $urandom_range(0, 4095);
        ay = $urandom_range(0, 4095);
        aw = random_span();
        ah = random_span();
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            bx = $urandom_range(0, 4095);
            by = $urandom_range(0, 4095);
            bw = random_span();
            bh = random_span();
        end
        else if (kind < 4)
        begin
            bw = $urandom_range(0, aw);
            bh = $urandom_range(0, ah);
            bx = ax + int'($urandom_range(0, aw - bw));
            by = ay + int'($urandom_range(0, ah - bh));
        end
        else if (kind < 9)
        begin
            bw = random_span();
            bh = random_span();
            bx = ax + int'($urandom_range(0, aw + bw)) - bw;
            by = ay + int'($urandom_range(0, ah + bh)) - bh;
        end
        else
        begin
            bx = ax;
            bw = aw;
            bh = random_span();
            by = ay + int'($urandom_range(0, ah + bh)) - bh;
        end
        if ($urandom_range(0, 1))
            return make_pair(bx, by, bw, bh, ax, ay, aw, ah);
        return make_pair(ax, ay, aw, ah, bx, by, bw, bh);
    endfunction

    // leaves the word and box_valid on the bus after acceptance; the next call replaces it, a drain drops box_valid
    task automatic send_box(input box_pair_t p);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            box_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        box_a_x   <= p.ax;
        box_a_y   <= p.ay;
        box_a_w   <= p.aw;
        box_a_h   <= p.ah;
        box_b_x   <= p.bx;
        box_b_y   <= p.by;
        box_b_w   <= p.bw;
        box_b_h   <= p.bh;
        box_valid <= 1'b1;
        @(negedge clk);
        while (box_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain_boxes();
        box_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_inclusion(input logic skip);
        drain_boxes();
        ignore_inclusion <= skip;
        cfg_valid        <= 1'b1;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_corner_cases();
        quiet = 1'b0;
        send_box(make_pair(0, 0, 1, 1, 0, 0, 1, 1));
        send_box(make_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
        send_box(make_pair(0, 0, 10, 10, 20, 20, 5, 5));
        send_box(make_pair(0, 0, 10, 10, 30, 2, 5, 5));
        // edges that only touch
        send_box(make_pair(0, 0, 10, 10, 10, 0, 10, 10));
        send_box(make_pair(0, 0, 10, 10, 10, 10, 10, 10));
        send_box(make_pair(0, 0, 100, 100, 10, 10, 5, 5));
        send_box(make_pair(10, 10, 5, 5, 0, 0, 100, 100));
        send_box(make_pair(0, 0, 10, 10, 5, 5, 10, 10));
        send_box(make_pair(0, 0, 10, 10, 0, 5, 10, 10));
        // zero-sized boxes
        send_box(make_pair(5, 5, 0, 10, 0, 0, 20, 20));
        send_box(make_pair(3, 3, 0, 0, 3, 3, 0, 0));
        send_box(make_pair(0, 0, 0, 5, 0, 0, 5, 0));
        send_box(make_pair(0, 0, 0, 0, 4095, 4095, 0, 0));
        send_box(make_pair(0, 0, 4095, 4095, 4095, 4095, 4095, 4095));
        send_box(make_pair(0, 0, 4095, 4095, 1, 1, 4094, 4094));
        send_box(make_pair(0, 0, 10, 10, 0, 0, 10, 5));
        send_box(make_pair(0, 0, 10, 10, 2, 0, 6, 12));
        send_box(make_pair(12'hAAA, 12'h555, 12'h555, 12'hAAA,
                           12'h555, 12'hAAA, 12'hAAA, 12'h555));
        send_box(make_pair(0, 0, 4095, 1, 0, 0, 1, 4095));
        send_box(make_pair(0, 0, 100, 1, 0, 0, 99, 1));
        send_box(make_pair(4095, 0, 1, 4095, 4095, 0, 4095, 4095));
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % QUIET_STRETCH == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send_box(random_pair());
        end
    endtask

    initial
    begin
        int hold;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = idle_cycles();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(negedge clk);
            while (!result_valid)
                @(negedge clk);
            @(posedge clk);
        end
    end

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        cfg_valid        <= 1'b0;
        ignore_inclusion <= 1'b0;
        box_valid        <= 1'b0;
        box_a_x          <= '0;
        box_a_y          <= '0;
        box_a_w          <= '0;
        box_a_h          <= '0;
        box_b_x          <= '0;
        box_b_y          <= '0;
        box_b_w          <= '0;
        box_b_h          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_inclusion(1'b0);
        run_corner_cases();
        write_inclusion(1'b1);
        run_corner_cases();
        write_inclusion(1'b0);
        run_random(290);
        drain_boxes();
        run_random(290);
        write_inclusion(1'b1);
        run_random(580);
        write_inclusion(1'b0);
        run_random(590);
        drain_boxes();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/bop_pkg.sv
sv/bop_geometry.sv
sv/bop_area.sv
sv/bop_divide.sv
sv/box_overlap_percent.sv
tb/sv/box_overlap_checker.sv
tb/sv/tb_box_overlap_percent.sv
